// ===== rtl/ts_packet_sync_aligner_top_assert.svh =====
// Assertion macros shared by the packet aligner checkers.
// Needs a clock and an active-low reset named at each use.
`ifndef TS_PACKET_SYNC_ALIGNER_TOP_ASSERT_SVH
`define TS_PACKET_SYNC_ALIGNER_TOP_ASSERT_SVH

// Consequent checked on the same edge as the antecedent.
`define TPSA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpsa assertion failed");

// Consequent checked on the edge after the antecedent.
`define TPSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpsa assertion failed");

`endif

// ===== rtl/tpsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types of the transport-stream packet aligner.
// No dependencies.
package tpsa_pkg;

    localparam int CHANNELS_DEF   = 4;
    localparam int PACKET_LEN_DEF = 188;
    localparam int CHAN_W         = 2;
    localparam int BYTE_W         = 8;
    localparam int CNT_W          = 8;
    localparam int OUT_DEPTH      = 4;

    localparam logic [BYTE_W-1:0] SYNC_VALUE = 8'h47;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // per-channel control word kept in the state memory
    typedef struct packed {
        logic [CNT_W-1:0] fill;
        logic [CNT_W-1:0] left;
        logic [CNT_W-1:0] ptr;
    } t_chan_state;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic [BYTE_W-1:0] pkt_byte;
        logic              first;
        logic              last;
    } t_result;

endpackage

// ===== rtl/tpsa_if.sv =====
`timescale 1ns / 1ps
// Request channels of the packet aligner: input items and aligned packet bytes.
// Depends on tpsa_pkg.
interface tpsa_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [tpsa_pkg::CHAN_W-1:0] channel;
    logic [tpsa_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output command, output channel, output data_byte,
                    input ready);
    modport sink   (input valid, input command, input channel, input data_byte,
                    output ready);
endinterface

interface tpsa_out_if;
    logic                        valid;
    logic                        ready;
    logic [tpsa_pkg::CHAN_W-1:0] out_channel;
    logic [tpsa_pkg::BYTE_W-1:0] packet_byte;
    logic                        first_of_packet;
    logic                        last_of_packet;

    modport source (output valid, output out_channel, output packet_byte,
                    output first_of_packet, output last_of_packet, input ready);
    modport sink   (input valid, input out_channel, input packet_byte,
                    input first_of_packet, input last_of_packet, output ready);
endinterface

// ===== rtl/tpsa_ram.sv =====
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// Read during write to the same address returns the old data. No dependencies.
module tpsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tpsa_out_fifo.sv =====
`timescale 1ns / 1ps
// Result queue between the aligner pipeline and the output channel.
// Depends on tpsa_pkg.
module tpsa_out_fifo #(
    parameter int DEPTH = tpsa_pkg::OUT_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tpsa_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_valid,
    output tpsa_pkg::t_result o_data,
    output logic [CW-1:0]     o_count
);

    tpsa_pkg::t_result r_buf [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

// ===== rtl/ts_packet_sync_aligner_top.sv =====
`timescale 1ns / 1ps
// Per-channel transport-stream packet aligner. Takes one request (data byte or
// flush) per clock while input ready is high, and gives at most one aligned
// packet byte for it. Each packet byte leaves one packet length after it
// arrived on its channel; the result passes the read and decide stages into
// the result queue. Per-channel counters live in a small state memory that is
// read when the request is taken and written back from the decide stage,
// with forwarding between back-to-back requests of one channel; the delay bytes
// live in a second memory accessed once per request. Input ready drops only
// when the four-entry result queue plus the requests in flight would overflow.
// Depends on tpsa_pkg, tpsa_if, tpsa_ram and tpsa_out_fifo.
module ts_packet_sync_aligner_top #(
    parameter int CHANNELS   = tpsa_pkg::CHANNELS_DEF,
    parameter int PACKET_LEN = tpsa_pkg::PACKET_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpsa_in_if.sink     i_in,
    tpsa_out_if.source  o_out
);

    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W     = tpsa_pkg::CNT_W;
    localparam int BYTE_W    = tpsa_pkg::BYTE_W;
    localparam int CHAN_W    = tpsa_pkg::CHAN_W;
    localparam int DLY_DEPTH = CHANNELS * PACKET_LEN;
    localparam int DLY_AW    = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
    localparam int ST_W      = $bits(tpsa_pkg::t_chan_state);
    localparam int OUT_DEPTH = tpsa_pkg::OUT_DEPTH;
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    logic                  accept;
    logic                  in_range;
    logic [CH_IDX_W-1:0]   in_idx;

    // read stage: state word arrives from memory
    logic                  r_s1_valid;
    logic                  r_s1_cmd;
    logic [CH_IDX_W-1:0]   r_s1_idx;
    logic [CHAN_W-1:0]     r_s1_ch;
    logic [BYTE_W-1:0]     r_s1_byte;
    logic                  r_s1_stvld;

    logic [ST_W-1:0]       st_rd_raw;
    tpsa_pkg::t_chan_state st_mem;
    tpsa_pkg::t_chan_state cur;
    tpsa_pkg::t_chan_state s1_next;
    logic                  s1_flush;
    logic                  s1_full;
    logic [DLY_AW-1:0]     dly_addr;
    logic [BYTE_W-1:0]     dly_rd;

    // decide stage: oldest byte arrives from the delay memory
    logic                  r_s2_valid;
    logic [CH_IDX_W-1:0]   r_s2_idx;
    logic [CHAN_W-1:0]     r_s2_ch;
    logic [BYTE_W-1:0]     r_s2_byte;
    logic                  r_s2_full;
    tpsa_pkg::t_chan_state r_s2_state;
    tpsa_pkg::t_chan_state s2_next;
    logic                  emit_cont;
    logic                  emit_first;
    logic                  push;
    tpsa_pkg::t_result     push_res;

    // last state write, for a read that raced it
    logic                  r_fw_valid;
    logic [CH_IDX_W-1:0]   r_fw_idx;
    tpsa_pkg::t_chan_state r_fw_state;

    logic [CHANNELS-1:0]   r_st_vld;

    logic                  fifo_valid;
    tpsa_pkg::t_result     fifo_head;
    logic [OUT_CW-1:0]     fifo_count;
    logic [OUT_CW:0]       occupancy;

    assign occupancy = {1'b0, fifo_count} + (OUT_CW + 1)'(r_s1_valid)
                     + (OUT_CW + 1)'(r_s2_valid);
    assign i_in.ready = (occupancy < (OUT_CW + 1)'(OUT_DEPTH));
    assign accept     = i_in.valid && i_in.ready;
    assign in_range   = (int'(i_in.channel) < CHANNELS);
    assign in_idx     = CH_IDX_W'(i_in.channel);

    tpsa_ram #(
        .WIDTH (ST_W),
        .DEPTH (CHANNELS),
        .AW    (CH_IDX_W)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (r_s2_valid),
        .i_waddr (r_s2_idx),
        .i_wdata (ST_W'(s2_next)),
        .i_re    (accept && in_range),
        .i_raddr (in_idx),
        .o_rdata (st_rd_raw)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_fw_valid <= 1'b0;
            r_st_vld   <= '0;
        end else begin
            r_s1_valid <= accept && in_range;
            r_s2_valid <= r_s1_valid;
            r_fw_valid <= r_s2_valid;
            if (r_s2_valid) begin
                r_st_vld[r_s2_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd   <= i_in.command;
            r_s1_idx   <= in_idx;
            r_s1_ch    <= i_in.channel;
            r_s1_byte  <= i_in.data_byte;
            r_s1_stvld <= r_st_vld[in_idx];
        end
        r_s2_idx   <= r_s1_idx;
        r_s2_ch    <= r_s1_ch;
        r_s2_byte  <= r_s1_byte;
        r_s2_full  <= s1_full && !s1_flush;
        r_s2_state <= s1_next;
        r_fw_idx   <= r_s2_idx;
        r_fw_state <= s2_next;
    end

    // a never-written channel reads as empty and searching
    assign st_mem = r_s1_stvld ? tpsa_pkg::t_chan_state'(st_rd_raw) : '0;

    always_comb begin
        if (r_s2_valid && (r_s2_idx == r_s1_idx)) begin
            cur = s2_next;
        end else if (r_fw_valid && (r_fw_idx == r_s1_idx)) begin
            cur = r_fw_state;
        end else begin
            cur = st_mem;
        end
    end

    assign s1_flush = (r_s1_cmd == tpsa_pkg::CMD_FLUSH);
    assign s1_full  = (cur.fill == CNT_W'(PACKET_LEN));

    always_comb begin
        s1_next = '0;
        if (!s1_flush) begin
            s1_next.fill = s1_full ? cur.fill : cur.fill + CNT_W'(1);
            s1_next.left = cur.left;
            s1_next.ptr  = (cur.ptr == CNT_W'(PACKET_LEN - 1)) ? '0 : cur.ptr + CNT_W'(1);
        end
    end

    assign dly_addr = DLY_AW'(int'(r_s1_idx) * PACKET_LEN + int'(cur.ptr));

    // read the oldest byte and store the newest in the same slot
    tpsa_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DLY_DEPTH),
        .AW    (DLY_AW)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid && !s1_flush),
        .i_waddr (dly_addr),
        .i_wdata (r_s1_byte),
        .i_re    (r_s1_valid),
        .i_raddr (dly_addr),
        .o_rdata (dly_rd)
    );

    assign emit_cont  = r_s2_full && (r_s2_state.left != '0);
    assign emit_first = r_s2_full && (r_s2_state.left == '0)
                      && (dly_rd == tpsa_pkg::SYNC_VALUE)
                      && (r_s2_byte == tpsa_pkg::SYNC_VALUE);

    always_comb begin
        s2_next = r_s2_state;
        if (emit_cont) begin
            s2_next.left = r_s2_state.left - CNT_W'(1);
        end else if (emit_first) begin
            s2_next.left = CNT_W'(PACKET_LEN - 1);
        end
    end

    assign push              = r_s2_valid && (emit_cont || emit_first);
    assign push_res.channel  = r_s2_ch;
    assign push_res.pkt_byte = dly_rd;
    assign push_res.first    = emit_first;
    assign push_res.last     = emit_cont && (r_s2_state.left == CNT_W'(1));

    tpsa_out_fifo #(
        .DEPTH (OUT_DEPTH),
        .CW    (OUT_CW)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_res),
        .i_pop   (o_out.ready),
        .o_valid (fifo_valid),
        .o_data  (fifo_head),
        .o_count (fifo_count)
    );

    assign o_out.valid           = fifo_valid;
    assign o_out.out_channel     = fifo_head.channel;
    assign o_out.packet_byte     = fifo_head.pkt_byte;
    assign o_out.first_of_packet = fifo_head.first;
    assign o_out.last_of_packet  = fifo_head.last;

endmodule

// ===== rtl/tpsa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the packet aligner output, bound to the top level.
// Depends on tpsa_pkg and ts_packet_sync_aligner_top_assert.svh.
`include "ts_packet_sync_aligner_top_assert.svh"

module tpsa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [tpsa_pkg::BYTE_W-1:0] i_out_byte,
    input logic                        i_out_first,
    input logic                        i_out_last
);

    // hold a stalled result
    `TPSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_byte) && $stable(i_out_first) && $stable(i_out_last))

    `TPSA_ASSERT_SAME(a_first_is_sync, i_clk, i_rst_n, i_out_valid && i_out_first,
        i_out_byte == tpsa_pkg::SYNC_VALUE)

    `TPSA_ASSERT_SAME(a_first_not_last, i_clk, i_rst_n, i_out_valid && i_out_first,
        !i_out_last)

    `TPSA_ASSERT_SAME(a_quiet_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid)

endmodule

bind ts_packet_sync_aligner_top tpsa_checker u_tpsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.packet_byte),
    .i_out_first (o_out.first_of_packet),
    .i_out_last  (o_out.last_of_packet)
);
